// File: rtl/lhbm_pkg.sv
// Shared types, register map and reset constants for the link health backoff monitor.
package lhbm_pkg;

  localparam int LHBM_CHANNELS = 16;

  localparam logic [15:0] CHECK_INTERVAL_RST  = 16'd30;
  localparam logic [7:0]  RESTART_LIMIT_RST   = 8'd5;
  localparam logic [15:0] BACKOFF_INITIAL_RST = 16'd2;
  localparam logic [15:0] BACKOFF_LIMIT_RST   = 16'd120;
  localparam logic [15:0] STALE_THRESHOLD_RST = 16'd300;

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_CHECK_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_RESTART_LIMIT   = 3'd1;
  localparam logic [2:0] REG_BACKOFF_INITIAL = 3'd2;
  localparam logic [2:0] REG_BACKOFF_LIMIT   = 3'd3;
  localparam logic [2:0] REG_STALE_THRESHOLD = 3'd4;

  localparam logic [1:0] MODE_CHECK  = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;
  localparam logic [1:0] MODE_ADD    = 2'd2;

  typedef struct packed {
    logic [15:0] check_interval;
    logic [7:0]  restart_limit;
    logic [15:0] backoff_initial;
    logic [15:0] backoff_limit;
    logic [15:0] stale_threshold;
  } lhbm_cfg_t;

  typedef struct packed {
    logic        healthy;
    logic [31:0] last_check_time;
    logic [31:0] last_event_time;
    logic [15:0] fail_run;
    logic [7:0]  restart_tally;
    logic [15:0] backoff_secs;
  } lhbm_entry_t;

  localparam int ENTRY_W = $bits(lhbm_entry_t);

  typedef struct packed {
    logic        found;
    logic        checked;
    logic        is_healthy;
    logic [15:0] failure_count;
    logic [7:0]  restarts_done;
    logic        restart_tried;
    logic [15:0] backoff_now;
    logic        stale_flag;
  } lhbm_result_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lhbm_state_t;

endpackage

// File: rtl/link_health_backoff_monitor_core.sv
// Top level of the link health backoff monitor: channel table, sequencer and output register.
//
//   Channel  Direction  Handshake                    Payload
//   in_      input      in_valid / in_ready          mode, channel_index, now_time,
//                                                     health_ok, restart_ok
//   out_     output     out_valid / out_ready        found, checked, is_healthy,
//                                                     failure_count, restarts_done,
//                                                     restart_tried, backoff_now, stale_flag
//   cfg      config     psel, penable, pwrite, ...   five registers at 4*index
//
// Each transaction first reads the table entry from the RAM, whose
// read data is registered, and then updates it and writes it back.
// A new transaction is accepted while the previous result waits in the output register.
// A finished update waits in place while the output register is still full.
// Reset is synchronous and clears the per-channel valid flags, so no clearing pass is needed.
module link_health_backoff_monitor_core
  import lhbm_pkg::*;
#(
  parameter int CHANNELS = LHBM_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [3:0]        in_channel_index,
  input  logic [31:0]       in_now_time,
  input  logic              in_health_ok,
  input  logic              in_restart_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic              out_checked,
  output logic              out_is_healthy,
  output logic [15:0]       out_failure_count,
  output logic [7:0]        out_restarts_done,
  output logic              out_restart_tried,
  output logic [15:0]       out_backoff_now,
  output logic              out_stale_flag,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW = (AW > 4) ? AW : 4;

  lhbm_cfg_t     cfg;
  lhbm_state_t   state_r, state_nxt;
  logic [1:0]    mode_r;
  logic [3:0]    ch_r;
  logic [31:0]   now_r;
  logic          health_r;
  logic          restart_r;
  logic          in_acc;
  logic          advance;
  logic [EW-1:0] idx_ext;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          hit;
  logic [CHANNELS-1:0] valid_r, valid_nxt;
  logic [ENTRY_W-1:0]  ram_rdata;
  lhbm_entry_t   cur;
  lhbm_entry_t   upd;
  logic          wr_en;
  logic          set_valid;
  lhbm_result_t  res;
  lhbm_result_t  res_r;
  logic          out_valid_r, out_valid_nxt;

  lhbm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign advance  = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);

  assign idx_ext  = EW'(ch_r);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = 32'(ch_r) < 32'(CHANNELS);
  assign hit      = in_range && valid_r[addr];
  assign cur      = hit ? lhbm_entry_t'(ram_rdata) : '0;

  logic [EW-1:0] rd_idx_ext;
  assign rd_idx_ext = EW'(in_channel_index);

  lhbm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (advance && wr_en),
    .waddr (addr),
    .wdata (upd),
    .re    (in_acc),
    .raddr (rd_idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  lhbm_step u_step (
    .cfg        (cfg),
    .mode       (mode_r),
    .in_range   (in_range),
    .hit        (hit),
    .now_time   (now_r),
    .health_ok  (health_r),
    .restart_ok (restart_r),
    .cur        (cur),
    .wr_en      (wr_en),
    .set_valid  (set_valid),
    .upd        (upd),
    .res        (res)
  );

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (advance) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (set_valid) begin
            valid_nxt[addr] = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r    <= in_mode;
      ch_r      <= in_channel_index;
      now_r     <= in_now_time;
      health_r  <= in_health_ok;
      restart_r <= in_restart_ok;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = res_r.found;
  assign out_checked       = res_r.checked;
  assign out_is_healthy    = res_r.is_healthy;
  assign out_failure_count = res_r.failure_count;
  assign out_restarts_done = res_r.restarts_done;
  assign out_restart_tried = res_r.restart_tried;
  assign out_backoff_now   = res_r.backoff_now;
  assign out_stale_flag    = res_r.stale_flag;

endmodule

// File: rtl/lhbm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module lhbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lhbm_cfg_regs.sv
// APB-style configuration register file for the link health backoff monitor.
module lhbm_cfg_regs
  import lhbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lhbm_cfg_t         cfg
);

  lhbm_cfg_t   cfg_r;
  lhbm_cfg_t   cfg_nxt;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_CHECK_INTERVAL:  cfg_nxt.check_interval  = pwdata[15:0];
        REG_RESTART_LIMIT:   cfg_nxt.restart_limit   = pwdata[7:0];
        REG_BACKOFF_INITIAL: cfg_nxt.backoff_initial = pwdata[15:0];
        REG_BACKOFF_LIMIT:   cfg_nxt.backoff_limit   = pwdata[15:0];
        REG_STALE_THRESHOLD: cfg_nxt.stale_threshold = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_interval  <= CHECK_INTERVAL_RST;
      cfg_r.restart_limit   <= RESTART_LIMIT_RST;
      cfg_r.backoff_initial <= BACKOFF_INITIAL_RST;
      cfg_r.backoff_limit   <= BACKOFF_LIMIT_RST;
      cfg_r.stale_threshold <= STALE_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHECK_INTERVAL:  prdata = {16'd0, cfg_r.check_interval};
      REG_RESTART_LIMIT:   prdata = {24'd0, cfg_r.restart_limit};
      REG_BACKOFF_INITIAL: prdata = {16'd0, cfg_r.backoff_initial};
      REG_BACKOFF_LIMIT:   prdata = {16'd0, cfg_r.backoff_limit};
      REG_STALE_THRESHOLD: prdata = {16'd0, cfg_r.stale_threshold};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/lhbm_step.sv
// Entry update logic: add, record and check with interval and backoff skips.
module lhbm_step
  import lhbm_pkg::*;
(
  input  lhbm_cfg_t    cfg,
  input  logic [1:0]   mode,
  input  logic         in_range,
  input  logic         hit,
  input  logic [31:0]  now_time,
  input  logic         health_ok,
  input  logic         restart_ok,
  input  lhbm_entry_t  cur,
  output logic         wr_en,
  output logic         set_valid,
  output lhbm_entry_t  upd,
  output lhbm_result_t res
);

  logic signed [33:0] since;
  logic signed [33:0] quiet;
  logic               skip;
  logic [15:0]        fail_sat;
  logic               tried;
  logic               recovered;
  logic [15:0]        base_bo;
  logic [16:0]        doubled;

  assign since = $signed({2'b00, now_time}) - $signed({2'b00, cur.last_check_time});
  assign quiet = $signed({2'b00, now_time}) - $signed({2'b00, cur.last_event_time});

  assign skip = (cur.last_check_time != 32'd0) &&
                ((since < $signed({18'd0, cfg.check_interval})) ||
                 ((cur.fail_run != 16'd0) && (since < $signed({18'd0, cur.backoff_secs}))));

  assign fail_sat  = (cur.fail_run == 16'hFFFF) ? cur.fail_run : cur.fail_run + 16'd1;
  assign tried     = cur.restart_tally < cfg.restart_limit;
  assign recovered = tried && restart_ok;
  assign base_bo   = recovered ? cfg.backoff_initial : cur.backoff_secs;
  assign doubled   = {base_bo, 1'b0};

  always_comb begin
    wr_en     = 1'b0;
    set_valid = 1'b0;
    upd       = cur;
    res       = '0;
    if (in_range && (mode == MODE_ADD)) begin
      wr_en     = 1'b1;
      set_valid = 1'b1;
      upd       = '0;
      upd.healthy      = 1'b1;
      upd.backoff_secs = cfg.backoff_initial;
    end else if (hit && (mode == MODE_RECORD)) begin
      wr_en               = 1'b1;
      upd.last_event_time = cur.last_check_time;
      res.found           = 1'b1;
    end else if (hit && (mode == MODE_CHECK)) begin
      res.found = 1'b1;
      if (!skip) begin
        wr_en               = 1'b1;
        res.checked         = 1'b1;
        upd.last_check_time = now_time;
        if (health_ok) begin
          upd.healthy      = 1'b1;
          upd.fail_run     = 16'd0;
          upd.backoff_secs = cfg.backoff_initial;
        end else begin
          upd.healthy  = recovered;
          upd.fail_run = recovered ? 16'd0 : fail_sat;
          if (tried) begin
            upd.restart_tally = cur.restart_tally + 8'd1;
          end
          res.restart_tried = tried;
          upd.backoff_secs  = (doubled > {1'b0, cfg.backoff_limit}) ?
                              cfg.backoff_limit : doubled[15:0];
        end
        res.stale_flag = (cfg.stale_threshold != 16'd0) &&
                         (cur.last_event_time != 32'd0) &&
                         (quiet > $signed({18'd0, cfg.stale_threshold})) &&
                         upd.healthy;
      end
    end
    if (res.found || set_valid) begin
      res.is_healthy    = upd.healthy;
      res.failure_count = upd.fail_run;
      res.restarts_done = upd.restart_tally;
      res.backoff_now   = upd.backoff_secs;
    end
  end

endmodule
